[rtl/totp_pkg.sv]
// Shared types, constants and helper functions for the TOTP HMAC-SHA256 engine.
// No dependencies.
package totp_pkg;

	localparam int MaxKeyBytes = 32;
	localparam int KeyLenW     = 6;
	localparam int CodeW       = 30;

	localparam logic [2:0] CfgKey0   = 3'd0;
	localparam logic [2:0] CfgKey1   = 3'd1;
	localparam logic [2:0] CfgKey2   = 3'd2;
	localparam logic [2:0] CfgKey3   = 3'd3;
	localparam logic [2:0] CfgKeyLen = 3'd4;
	localparam logic [2:0] CfgStep   = 3'd5;
	localparam logic [2:0] CfgDigits = 3'd6;

	// Which message block the datapath loads before a compression.
	typedef enum logic [1:0] {
		BLK_IPAD,
		BLK_MSG1,
		BLK_OPAD,
		BLK_MSG2
	} blk_sel_t;

	typedef struct packed {
		logic     div_start;   // start 64/32 division
		logic     div_bypass;  // counter given directly
		logic     load_iv;     // hash state <= initial value
		logic     load_blk;    // load schedule window with a block
		blk_sel_t blk;
		logic     round;       // run one compression round
		logic     fold;        // add working vars into hash state
		logic     save_inner;  // keep inner digest
		logic     trunc;       // dynamic truncation
		logic     mod_start;   // start modulo reduction
	} totp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mod_done;
	} totp_sts_t;

	function automatic logic [31:0] k256(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	localparam logic [255:0] HashIv = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [29:0] pow10(input logic [3:0] n);
		logic [29:0] p;
		case (n)
			4'd2: p = 30'd100;
			4'd3: p = 30'd1000;
			4'd4: p = 30'd10000;
			4'd5: p = 30'd100000;
			4'd6: p = 30'd1000000;
			4'd7: p = 30'd10000000;
			4'd8: p = 30'd100000000;
			4'd9: p = 30'd1000000000;
			default: p = 30'd10;
		endcase
		return p;
	endfunction

endpackage

[rtl/totp_hmac_sha256_engine_core.sv]
// Top level of the TOTP HMAC-SHA256 engine: configuration registers and wiring.
// Depends on totp_pkg, totp_ctrl and totp_datapath.
//
// One request is worked at a time. A time input first runs a restoring divide
// by the configured step length; then four SHA-256 compressions run one round
// per cycle, followed by a shift-subtract reduction modulo 10^digits. A counter
// input skips the divide. The result is held until taken.
module totp_hmac_sha256_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [29:0] code,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import totp_pkg::*;

	logic [255:0] key_q;
	logic [5:0]   key_length_q;
	logic [31:0]  step_len_q;
	logic [3:0]   digits_q;
	totp_cmd_t    cmd;
	totp_sts_t    sts;
	logic [5:0]   round_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q        <= '0;
			key_length_q <= 6'd20;
			step_len_q   <= 32'd30;
			digits_q     <= 4'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgKey0:   key_q[255:192] <= cfg_data;
				CfgKey1:   key_q[191:128] <= cfg_data;
				CfgKey2:   key_q[127:64]  <= cfg_data;
				CfgKey3:   key_q[63:0]    <= cfg_data;
				CfgKeyLen: key_length_q   <= cfg_data[5:0];
				CfgStep:   step_len_q     <= cfg_data[31:0];
				CfgDigits: digits_q       <= cfg_data[3:0];
				default:   ;
			endcase
		end
	end

	totp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.round_idx(round_idx),
		.sts      (sts)
	);

	totp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.round_idx (round_idx),
		.sts       (sts),
		.key       (key_q),
		.key_length(key_length_q),
		.step_len  (step_len_q),
		.digits    (digits_q),
		.value     (value),
		.code      (code)
	);
endmodule

[rtl/totp_sha_core.sv]
// One SHA-256 round per cycle over a 16-word rolling message schedule.
// Depends on totp_pkg.
module totp_sha_core (
	input  logic         clk,
	input  logic         load_iv,
	input  logic         load_blk,
	input  logic [511:0] blk,
	input  logic         round,
	input  logic [5:0]   round_idx,
	input  logic         fold,
	output logic [255:0] digest
);
	import totp_pkg::*;

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] s0, s1, wn, t1, t2, ch, maj, e0, e1;
	logic [31:0] a, b, c, d, e, f, g, hh;

	function automatic logic [31:0] rr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	assign {a, b, c, d, e, f, g, hh} = {v_q[0], v_q[1], v_q[2], v_q[3],
		v_q[4], v_q[5], v_q[6], v_q[7]};

	always_comb begin
		s0  = rr(w_q[1], 7) ^ rr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1  = rr(w_q[14], 17) ^ rr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn  = w_q[0] + s0 + w_q[9] + s1;
		e1  = rr(e, 6) ^ rr(e, 11) ^ rr(e, 25);
		ch  = (e & f) ^ (~e & g);
		e0  = rr(a, 2) ^ rr(a, 13) ^ rr(a, 22);
		maj = (a & b) ^ (a & c) ^ (b & c);
		t1  = hh + e1 + ch + k256(round_idx) + w_q[0];
		t2  = e0 + maj;
	end

	always_ff @(posedge clk) begin
		if (load_iv) begin
			for (int i = 0; i < 8; i++) h_q[i] <= HashIv[255 - 32*i -: 32];
		end else if (fold) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
		if (load_blk) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= load_iv ? HashIv[255 - 32*i -: 32]
				: h_q[i];
		end else if (round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[0] <= t1 + t2;
			v_q[1] <= a; v_q[2] <= b; v_q[3] <= c;
			v_q[4] <= d + t1;
			v_q[5] <= e; v_q[6] <= f; v_q[7] <= g;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = h_q[i];
	end
endmodule

[rtl/totp_datapath.sv]
// Datapath: counter division, block assembly, SHA-256 core, truncation and modulo.
// Depends on totp_pkg and totp_sha_core.
module totp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  totp_pkg::totp_cmd_t cmd,
	input  logic [5:0]          round_idx,
	output totp_pkg::totp_sts_t sts,
	input  logic [255:0]        key,
	input  logic [5:0]          key_length,
	input  logic [31:0]         step_len,
	input  logic [3:0]          digits,
	input  logic [63:0]         value,
	output logic [29:0]         code
);
	import totp_pkg::*;

	logic [63:0]  quo_q;
	logic [31:0]  rem_q;
	logic [31:0]  step_q;
	logic [6:0]   dcnt_q;
	logic         dbusy_q;
	logic [32:0]  dtrial;
	logic [255:0] kmask;
	logic [511:0] blk;
	logic [255:0] digest;
	logic [255:0] inner_q;
	logic [30:0]  bin_q;
	logic [29:0]  mod_q;
	logic [30:0]  mrem_q;
	logic [4:0]   mcnt_q;
	logic         mbusy_q;
	logic [60:0]  msub;
	logic [6:0]   klen;
	logic [3:0]   off;
	logic [31:0]  word;
	logic [60:0]  mshift;

	assign klen = (key_length > 6'(MaxKeyBytes)) ? 7'(MaxKeyBytes) : {1'b0, key_length};

	always_comb begin
		for (int i = 0; i < 32; i++)
			kmask[255 - 8*i -: 8] = (7'(i) < klen) ? key[255 - 8*i -: 8] : 8'h00;
	end

	always_comb begin
		unique case (cmd.blk)
			BLK_IPAD: blk = {kmask ^ {32{8'h36}}, {32{8'h36}}};
			BLK_OPAD: blk = {kmask ^ {32{8'h5c}}, {32{8'h5c}}};
			BLK_MSG1: blk = {quo_q, 8'h80, 376'd0, 64'd576};
			default:  blk = {inner_q, 8'h80, 184'd0, 64'd768};
		endcase
	end

	totp_sha_core u_sha (
		.clk      (clk),
		.load_iv  (cmd.load_iv),
		.load_blk (cmd.load_blk),
		.blk      (blk),
		.round    (cmd.round),
		.round_idx(round_idx),
		.fold     (cmd.fold),
		.digest   (digest)
	);

	// restoring divide, one quotient bit per cycle
	assign dtrial = {rem_q, quo_q[63]} - {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			if (cmd.div_start && !cmd.div_bypass) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= 7'd0;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 7'd1;
				if (dcnt_q == 7'd63) dbusy_q <= 1'b0;
			end
			if (cmd.mod_start) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= 5'd30;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q - 5'd1;
				if (mcnt_q == 5'd0) mbusy_q <= 1'b0;
			end
		end
	end

	assign sts.div_done = dbusy_q && dcnt_q == 7'd63;
	assign sts.mod_done = mbusy_q && mcnt_q == 5'd0;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q  <= value;
			rem_q  <= '0;
			step_q <= (step_len == '0) ? 32'd1 : step_len;
		end else if (dbusy_q) begin
			if (!dtrial[32]) begin
				rem_q <= dtrial[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.save_inner) inner_q <= digest;
	end

	assign off  = digest[3:0];
	assign word = digest[255 - 8*off -: 32];

	// shift-subtract modulo: subtract mod << k for k from 30 down to 0
	assign mshift = {31'd0, mod_q} << mcnt_q;
	assign msub   = {30'd0, mrem_q} - mshift;

	always_ff @(posedge clk) begin
		if (cmd.trunc) bin_q <= word[30:0];
		if (cmd.mod_start) begin
			mrem_q <= bin_q;
			mod_q  <= pow10((digits == 4'd0) ? 4'd1 : (digits > 4'd9 ? 4'd9 : digits));
		end else if (mbusy_q && !msub[60]) begin
			mrem_q <= msub[30:0];
		end
	end

	assign code = mrem_q[29:0];
endmodule

[rtl/totp_ctrl.sv]
// Sequencer for the four compressions, division, truncation and reduction.
// Depends on totp_pkg.
module totp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	output logic                out_valid,
	input  logic                out_stall,
	output totp_pkg::totp_cmd_t cmd,
	output logic [5:0]          round_idx,
	input  totp_pkg::totp_sts_t sts
);
	import totp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_LOAD, ST_ROUND, ST_FOLD, ST_TRUNC, ST_MOD, ST_OUT
	} state_t;

	state_t      state_q;
	logic [1:0]  blk_q;
	logic [5:0]  rnd_q;
	logic        in_acc;
	logic        out_acc;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = !(state_q == ST_IDLE);
	assign out_valid = state_q == ST_OUT;
	assign round_idx = rnd_q;

	always_comb begin
		cmd            = '0;
		cmd.blk        = blk_sel_t'(blk_q);
		cmd.div_start  = in_acc;
		cmd.div_bypass = func;
		cmd.load_blk   = state_q == ST_LOAD;
		cmd.load_iv    = state_q == ST_LOAD && (blk_q == 2'd0 || blk_q == 2'd2);
		cmd.round      = state_q == ST_ROUND;
		cmd.fold       = state_q == ST_FOLD;
		cmd.save_inner = state_q == ST_TRUNC && blk_q == 2'd1;
		cmd.trunc      = state_q == ST_TRUNC && blk_q == 2'd3;
		cmd.mod_start  = state_q == ST_MOD && rnd_q == 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blk_q   <= '0;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					blk_q <= 2'd0;
					if (in_acc) state_q <= func ? ST_LOAD : ST_DIV;
				end
				ST_DIV:   if (sts.div_done) state_q <= ST_LOAD;
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: state_q <= (blk_q == 2'd0 || blk_q == 2'd2) ? ST_LOAD : ST_TRUNC;
				ST_TRUNC: begin
					// digest settled after fold; inner saved or truncation captured
					if (blk_q == 2'd1) begin
						blk_q   <= 2'd2;
						state_q <= ST_LOAD;
					end else begin
						rnd_q   <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					rnd_q <= 6'd1;
					if (sts.mod_done) state_q <= ST_OUT;
				end
				ST_OUT:   if (out_acc) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FOLD && (blk_q == 2'd0 || blk_q == 2'd2))
				blk_q <= blk_q + 2'd1;
		end
	end
endmodule
